// ----- hdl/lr_pkg.sv -----
// Shared types and constants for the line rasterizer.
package lr_pkg;

  localparam int COORD_BITS = 10;
  localparam int ERR_BITS   = COORD_BITS + 2;
  localparam int COLOR_BITS = 16;
  localparam int SIZE_BITS  = 11;
  localparam int CFG_IDX_BITS = 1;

  localparam logic [SIZE_BITS-1:0] SCREEN_WIDTH_RESET  = SIZE_BITS'(176);
  localparam logic [SIZE_BITS-1:0] SCREEN_HEIGHT_RESET = SIZE_BITS'(220);

  localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_HEIGHT = 1'b1;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_STEP  = 1'b1;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic                  kind;
    coord_t                start_x;
    coord_t                start_y;
    coord_t                end_x;
    coord_t                end_y;
    logic [COLOR_BITS-1:0] pen_color;
  } lr_in_t;

  typedef struct packed {
    coord_t                pixel_x;
    coord_t                pixel_y;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  on_screen;
    logic                  last;
  } lr_out_t;

  // Classified command held in the queue between front and engine
  typedef struct packed {
    logic                  is_start;
    logic                  steep;
    coord_t                a_maj;
    coord_t                a_min;
    coord_t                b_maj;
    coord_t                b_min;
    logic [COLOR_BITS-1:0] color;
  } lr_cmd_t;

  typedef struct packed {
    logic    valid;
    lr_cmd_t cmd;
  } lr_qhead_t;

endpackage

// ----- hdl/lr_front.sv -----
// Front end: accepts input words and classifies them into queue commands.
module lr_front (
  input  logic           in_valid,
  output logic           in_stall,
  input  lr_pkg::lr_in_t in_word,
  output logic           push,
  output lr_pkg::lr_cmd_t push_cmd,
  input  logic           q_full
);
  import lr_pkg::*;

  coord_t dx;
  coord_t dy;
  logic   steep;

  assign dx    = (in_word.start_x > in_word.end_x) ? in_word.start_x - in_word.end_x
                                                   : in_word.end_x - in_word.start_x;
  assign dy    = (in_word.start_y > in_word.end_y) ? in_word.start_y - in_word.end_y
                                                   : in_word.end_y - in_word.start_y;
  // y is the major axis only when it strictly dominates
  assign steep = dy > dx;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_cmd.is_start = (in_word.kind == KIND_START);
    push_cmd.steep    = steep;
    push_cmd.a_maj    = steep ? in_word.start_y : in_word.start_x;
    push_cmd.a_min    = steep ? in_word.start_x : in_word.start_y;
    push_cmd.b_maj    = steep ? in_word.end_y   : in_word.end_x;
    push_cmd.b_min    = steep ? in_word.end_x   : in_word.end_y;
    push_cmd.color    = in_word.pen_color;
  end

endmodule

// ----- hdl/lr_queue.sv -----
// Two-entry command queue between the front end and the line engine.
module lr_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lr_pkg::lr_cmd_t  push_cmd,
  output logic             full,
  output lr_pkg::lr_qhead_t head,
  input  logic             pop
);
  import lr_pkg::*;

  lr_cmd_t    mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head.valid = (count != 2'd0);
  assign head.cmd   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ----- hdl/lr_engine.sv -----
// Line engine: Bresenham state, per-step update and the output register.
module lr_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  lr_pkg::lr_qhead_t             head,
  output logic                          pop,
  input  logic [lr_pkg::SIZE_BITS-1:0]  screen_width,
  input  logic [lr_pkg::SIZE_BITS-1:0]  screen_height,
  output logic                          out_valid,
  input  logic                          out_stall,
  output lr_pkg::lr_out_t               out_word
);
  import lr_pkg::*;

  logic                         line_active;
  logic                         axes_swapped;
  logic                         minor_step_down;
  coord_t                       major_pos;
  coord_t                       minor_pos;
  coord_t                       major_end;
  coord_t                       major_delta;
  coord_t                       minor_delta;
  logic signed [ERR_BITS-1:0]   error_term;
  logic [COLOR_BITS-1:0]        line_color;

  logic                         out_free;
  logic                         emit;
  logic                         do_start;
  logic                         is_last;
  coord_t                       px;
  coord_t                       py;
  logic signed [ERR_BITS-1:0]   err_sub;

  // start setup
  logic   swap_ends;
  coord_t lo_maj;
  coord_t lo_min;
  coord_t hi_maj;
  coord_t hi_min;

  assign out_free = !out_valid || !out_stall;
  assign pop      = head.valid && (head.cmd.is_start || !line_active || out_free);
  assign do_start = pop && head.cmd.is_start;
  assign emit     = pop && !head.cmd.is_start && line_active;

  assign px      = axes_swapped ? minor_pos : major_pos;
  assign py      = axes_swapped ? major_pos : minor_pos;
  assign is_last = (major_pos >= major_end);
  assign err_sub = error_term - $signed({2'b00, minor_delta});

  assign swap_ends = head.cmd.a_maj > head.cmd.b_maj;
  assign lo_maj    = swap_ends ? head.cmd.b_maj : head.cmd.a_maj;
  assign lo_min    = swap_ends ? head.cmd.b_min : head.cmd.a_min;
  assign hi_maj    = swap_ends ? head.cmd.a_maj : head.cmd.b_maj;
  assign hi_min    = swap_ends ? head.cmd.a_min : head.cmd.b_min;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_active     <= 1'b0;
      axes_swapped    <= 1'b0;
      minor_step_down <= 1'b0;
      major_pos       <= '0;
      minor_pos       <= '0;
      major_end       <= '0;
      major_delta     <= '0;
      minor_delta     <= '0;
      error_term      <= '0;
      line_color      <= '0;
    end else if (do_start) begin
      line_active     <= 1'b1;
      axes_swapped    <= head.cmd.steep;
      minor_step_down <= !(lo_min < hi_min);
      major_pos       <= lo_maj;
      minor_pos       <= lo_min;
      major_end       <= hi_maj;
      major_delta     <= hi_maj - lo_maj;
      minor_delta     <= (lo_min > hi_min) ? lo_min - hi_min : hi_min - lo_min;
      error_term      <= $signed({3'b000, (COORD_BITS-1)'((hi_maj - lo_maj) >> 1)});
      line_color      <= head.cmd.color;
    end else if (emit) begin
      if (is_last) begin
        line_active <= 1'b0;
      end else begin
        if (err_sub < 0) begin
          minor_pos  <= minor_step_down ? minor_pos - coord_t'(1) : minor_pos + coord_t'(1);
          error_term <= err_sub + $signed({2'b00, major_delta});
        end else begin
          error_term <= err_sub;
        end
        major_pos <= major_pos + coord_t'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_word.pixel_x     <= px;
      out_word.pixel_y     <= py;
      out_word.pixel_color <= line_color;
      out_word.on_screen   <= ({1'b0, px} < screen_width) && ({1'b0, py} < screen_height);
      out_word.last        <= is_last;
    end
  end

endmodule

// ----- hdl/line_rasterizer.sv -----
// Top level of the line rasterizer: front end, queue, engine and screen registers.
//
//   port group   dir  handshake            payload
//   in_*         in   in_valid / in_stall  in_word  (lr_in_t)
//   out_*        out  out_valid / out_stall out_word (lr_out_t)
//   cfg_*        in   cfg_we               cfg_index, cfg_data
//
// One word per cycle sustained while out_stall is low: a step word is one subtract
// and compare on the registered error term in the engine. An accepted word is
// registered in the queue, and its pixel then in the output register (out_word).
// Reset empties the queue, drops any active line and restores 176 x 220.
// out_stall holds the output register; the two-entry queue then fills and
// raises in_stall. Start words and steps without a line never wait on output.
module line_rasterizer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  lr_pkg::lr_in_t                  in_word,
  output logic                            out_valid,
  input  logic                            out_stall,
  output lr_pkg::lr_out_t                 out_word,
  input  logic                            cfg_we,
  input  logic [lr_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [lr_pkg::SIZE_BITS-1:0]    cfg_data
);
  import lr_pkg::*;

  logic [SIZE_BITS-1:0] screen_width;
  logic [SIZE_BITS-1:0] screen_height;

  logic      push;
  lr_cmd_t   push_cmd;
  logic      q_full;
  lr_qhead_t head;
  logic      pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_WIDTH_RESET;
      screen_height <= SCREEN_HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        CFG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  lr_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .push     (push),
    .push_cmd (push_cmd),
    .q_full   (q_full)
  );

  lr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .head     (head),
    .pop      (pop)
  );

  lr_engine u_engine (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .pop           (pop),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_word      (out_word)
  );

endmodule

// ----- hdl/lr_checker.sv -----
// Port-level checks for the line rasterizer and their binding.
module lr_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input lr_pkg::lr_out_t                 out_word,
  input logic                            cfg_we,
  input logic [lr_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input logic [lr_pkg::SIZE_BITS-1:0]    cfg_data
);
  import lr_pkg::*;

  // shadow copy of the screen size, written from the port
  logic [SIZE_BITS-1:0] width_seen;
  logic [SIZE_BITS-1:0] height_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_seen  <= SCREEN_WIDTH_RESET;
      height_seen <= SCREEN_HEIGHT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_SCREEN_WIDTH)  width_seen  <= cfg_data;
      if (cfg_index == CFG_SCREEN_HEIGHT) height_seen <= cfg_data;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("output word dropped or changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not empty after reset");

  a_clip: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_word.on_screen ==
      (({1'b0, out_word.pixel_x} < width_seen) && ({1'b0, out_word.pixel_y} < height_seen)))
    else $error("on_screen disagrees with pixel position and screen size");

  a_out_known: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !$isunknown(out_word))
    else $error("output word has unknown bits while valid");

endmodule

bind line_rasterizer lr_checker u_lr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word),
  .cfg_we    (cfg_we),
  .cfg_index (cfg_index),
  .cfg_data  (cfg_data)
);

// ----- tb/lr_pixel_checker.sv -----
// Pixel checker for the line rasterizer: watches the ports, predicts each pixel and compares.
module lr_pixel_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  lr_pkg::lr_in_t                  in_word,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  lr_pkg::lr_out_t                 out_word,
  input  logic                            cfg_we,
  input  logic [lr_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [lr_pkg::SIZE_BITS-1:0]    cfg_data,
  output int                              fail_count,
  output int                              pending,
  output int                              pixels_checked,
  output int                              clipped_seen
);
  import lr_pkg::*;

  // screen size as the block should hold it
  logic [SIZE_BITS-1:0] width_lim, height_lim;

  // line walker state
  logic                       drawing, steep_line, minor_dec;
  coord_t                     maj_at, min_at, maj_stop, maj_span, min_span;
  logic signed [ERR_BITS-1:0] err_acc;
  logic [COLOR_BITS-1:0]      ink;

  lr_out_t pixel_q[$];

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // advance the walker by one accepted word; a step on a live line queues one pixel
  task automatic walk_line(input lr_in_t w);
    coord_t  dx, dy, p_maj, p_min, q_maj, q_min;
    lr_out_t px;
    logic    at_end;
    if (w.kind == KIND_START) begin
      dx = (w.start_x > w.end_x) ? w.start_x - w.end_x : w.end_x - w.start_x;
      dy = (w.start_y > w.end_y) ? w.start_y - w.end_y : w.end_y - w.start_y;
      steep_line = dy > dx;
      if (steep_line) begin
        p_maj = w.start_y; p_min = w.start_x; q_maj = w.end_y; q_min = w.end_x;
      end else begin
        p_maj = w.start_x; p_min = w.start_y; q_maj = w.end_x; q_min = w.end_y;
      end
      if (p_maj > q_maj) begin
        {p_maj, q_maj} = {q_maj, p_maj};
        {p_min, q_min} = {q_min, p_min};
      end
      maj_at    = p_maj;
      min_at    = p_min;
      maj_stop  = q_maj;
      maj_span  = q_maj - p_maj;
      min_span  = (p_min > q_min) ? p_min - q_min : q_min - p_min;
      minor_dec = !(p_min < q_min);
      err_acc   = ERR_BITS'(maj_span >> 1);
      ink       = w.pen_color;
      drawing   = 1'b1;
    end else if (drawing) begin
      px.pixel_x     = steep_line ? min_at : maj_at;
      px.pixel_y     = steep_line ? maj_at : min_at;
      px.pixel_color = ink;
      px.on_screen   = ({1'b0, px.pixel_x} < width_lim) && ({1'b0, px.pixel_y} < height_lim);
      at_end         = maj_at >= maj_stop;
      px.last        = at_end;
      pixel_q.push_back(px);
      if (at_end) begin
        drawing = 1'b0;
      end else begin
        err_acc = err_acc - $signed({2'b00, min_span});
        if (err_acc < 0) begin
          min_at  = minor_dec ? min_at - 1'b1 : min_at + 1'b1;
          err_acc = err_acc + $signed({2'b00, maj_span});
        end
        maj_at = maj_at + 1'b1;
      end
    end
  endtask

  always @(posedge clk) begin
    lr_out_t want;
    if (rst) begin
      width_lim      = SCREEN_WIDTH_RESET;
      height_lim     = SCREEN_HEIGHT_RESET;
      drawing        = 1'b0;
      steep_line     = 1'b0;
      minor_dec      = 1'b0;
      maj_at         = '0;
      min_at         = '0;
      maj_stop       = '0;
      maj_span       = '0;
      min_span       = '0;
      err_acc        = '0;
      ink            = '0;
      fail_count     = 0;
      pixels_checked = 0;
      clipped_seen   = 0;
      pixel_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        pixels_checked++;
        if (!out_word.on_screen) clipped_seen++;
        if (pixel_q.size() == 0) begin
          $error("pixel (%0d,%0d) out with none pending", out_word.pixel_x, out_word.pixel_y);
          fail_count++;
        end else begin
          want = pixel_q.pop_front();
          check_field("pixel_x", want.pixel_x, out_word.pixel_x);
          check_field("pixel_y", want.pixel_y, out_word.pixel_y);
          check_field("pixel_color", want.pixel_color, out_word.pixel_color);
          check_field("on_screen", want.on_screen, out_word.on_screen);
          check_field("last", want.last, out_word.last);
        end
      end
      if (in_valid && !in_stall) walk_line(in_word);
      if (cfg_we) begin
        if (cfg_index == CFG_SCREEN_WIDTH) width_lim = cfg_data;
        else if (cfg_index == CFG_SCREEN_HEIGHT) height_lim = cfg_data;
      end
    end
    pending = pixel_q.size();
  end

endmodule

// ----- tb/tb_top.sv -----
// Testbench top for the line rasterizer: clock, reset, stimulus, watchdog and verdict.
module tb_top;
  import lr_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_WAIT = 10;
  localparam int HOLD_LEN   = 100;

  logic                    clk, rst;
  logic                    in_valid, in_stall;
  lr_in_t                  in_word;
  logic                    out_valid, out_stall;
  lr_out_t                 out_word;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [SIZE_BITS-1:0]    cfg_data;

  int fail_count, pending, pixels_checked, clipped_seen;
  int words_sent  = 0;
  int starts_sent = 0;
  int idle_cycles = 0;
  bit tx_idle     = 1'b0;
  bit rx_idle     = 1'b0;
  bit hold_out    = 1'b0;

  line_rasterizer DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lr_pixel_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_word        (in_word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_word       (out_word),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pending        (pending),
    .pixels_checked (pixels_checked),
    .clipped_seen   (clipped_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog: too long without any word moving on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: %0d cycles without progress, %0d pixels pending", idle_cycles, pending);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // output side: random stall bursts, plus one long hold on request
  initial begin
    out_stall = 1'b0;
    wait (!rst);
    forever begin
      if (hold_out) begin
        out_stall = 1'b1;
        repeat (HOLD_LEN) @(negedge clk);
        hold_out = 1'b0;
      end else if (rx_idle && $urandom_range(0, 4) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end else begin
        out_stall = 1'b0;
        @(negedge clk);
      end
    end
  end

  task automatic send_word(input lr_in_t w);
    if (tx_idle && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_word  = w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    words_sent++;
    if (w.kind == KIND_START) starts_sent++;
  endtask

  task automatic send_start(input coord_t ax, input coord_t ay, input coord_t bx,
                            input coord_t by, input logic [COLOR_BITS-1:0] color);
    lr_in_t w;
    w.kind      = KIND_START;
    w.start_x   = ax;
    w.start_y   = ay;
    w.end_x     = bx;
    w.end_y     = by;
    w.pen_color = color;
    send_word(w);
  endtask

  // step words carry junk in the unused fields
  task automatic send_step();
    lr_in_t w;
    w.kind      = KIND_STEP;
    w.start_x   = coord_t'($urandom);
    w.start_y   = coord_t'($urandom);
    w.end_x     = coord_t'($urandom);
    w.end_y     = coord_t'($urandom);
    w.pen_color = COLOR_BITS'($urandom);
    send_word(w);
  endtask

  function automatic coord_t pick_coord();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return coord_t'($urandom_range(0, 1023));
  endfunction

  function automatic coord_t near_coord(input coord_t c, input int reach);
    int v;
    v = int'(c) + $urandom_range(0, 2 * reach) - reach;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return coord_t'(v);
  endfunction

  // one line: mostly drawn to the end, sometimes cut short or over-stepped
  task automatic send_line(input int reach);
    coord_t ax, ay, bx, by;
    int     dx, dy, len, n, r;
    ax = pick_coord();
    ay = pick_coord();
    bx = near_coord(ax, reach);
    by = near_coord(ay, reach);
    send_start(ax, ay, bx, by, COLOR_BITS'($urandom_range(0, 65535)));
    dx = int'(ax) - int'(bx);
    dy = int'(ay) - int'(by);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    len = ((dx > dy) ? dx : dy) + 1;
    r = $urandom_range(0, 9);
    if (r < 7) n = len;
    else if (r == 7) n = $urandom_range(0, len - 1);
    else n = len + $urandom_range(1, 3);
    repeat (n) send_step();
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_screen(input logic [CFG_IDX_BITS-1:0] idx,
                              input logic [SIZE_BITS-1:0] value);
    wait_drained();
    // starts or empty steps may still sit in the queue
    repeat (DRAIN_WAIT) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    int widths[6];
    int heights[6];
    int mark;
    widths  = '{176, 1, 1024, 0, 2047, 0};
    heights = '{220, 1024, 1, 2047, 0, 0};
    widths[5]  = $urandom_range(1, 1024);
    heights[5] = $urandom_range(1, 1024);

    rst       = 1'b1;
    in_valid  = 1'b0;
    in_word   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_SCREEN_WIDTH;
    cfg_data  = '0;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // directed: empty step, single-pixel line, full-range line replaced, steep and reversed
    send_step();
    send_start('0, '0, '0, '0, 16'h0000);
    send_step();
    send_step();
    send_start('0, '1, '1, '0, 16'hFFFF);
    repeat (3) send_step();
    send_start(10'd10, 10'd20, 10'd7, 10'd26, 16'hA5A5);
    repeat (7) send_step();
    send_start(10'd8, 10'd3, 10'd2, 10'd5, 16'h5A5A);
    repeat (7) send_step();
    send_start('1, '1, '1, '1, 16'h8001);
    send_step();

    for (int p = 0; p < 6; p++) begin
      if (p > 0) begin
        write_screen(CFG_SCREEN_WIDTH, SIZE_BITS'(widths[p]));
        write_screen(CFG_SCREEN_HEIGHT, SIZE_BITS'(heights[p]));
      end
      tx_idle = (p != 3) && (p != 5);
      rx_idle = (p != 3) && (p != 5);
      if (p == 1) begin
        // long output hold while words keep coming, so the queue backs up
        hold_out = 1'b1;
        tx_idle  = 1'b0;
        send_start(10'd100, 10'd100, 10'd130, 10'd110, 16'h07E0);
        repeat (31) send_step();
        tx_idle = 1'b1;
      end
      mark = words_sent;
      while (words_sent - mark < 70) begin
        send_line(($urandom_range(0, 19) == 0) ? 100 : 12);
        if (p == 2 && words_sent - mark >= 40 && words_sent - mark < 55) wait_drained();
      end
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(negedge clk);
    $display("covered %0d words (%0d line starts) across six screen sizes", words_sent,
             starts_sent);
    $display("%0d pixels checked, %0d of them clipped", pixels_checked, clipped_seen);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/lr_pkg.sv
hdl/lr_front.sv
hdl/lr_queue.sv
hdl/lr_engine.sv
hdl/line_rasterizer.sv
hdl/lr_checker.sv
tb/lr_pixel_checker.sv
tb/tb_top.sv
